### src/thwc_pkg.sv
// ----------------------------------------------------------------------------
// thwc_pkg
// Shared types and constants of the time histogram wake convolution unit.
// ----------------------------------------------------------------------------
package thwc_pkg;

  localparam logic [1:0] MODE_LOAD    = 2'd0;
  localparam logic [1:0] MODE_BIN     = 2'd1;
  localparam logic [1:0] MODE_COMPUTE = 2'd2;

  localparam logic [2:0] REG_FIRST  = 3'd0;
  localparam logic [2:0] REG_WIDTH  = 3'd1;
  localparam logic [2:0] REG_COUNT  = 3'd2;
  localparam logic [2:0] REG_WLEN   = 3'd3;
  localparam logic [2:0] REG_ORIGIN = 3'd4;
  localparam logic [2:0] REG_SCALE  = 3'd5;

  localparam int CFG_WIDTH = 32;

  // commands from controller to datapath
  typedef struct packed {
    logic div_start;   // load dividend/divisor, begin divide
    logic div_step;    // one restoring step
    logic bin_finish;  // update histogram from quotient, load bin result
    logic load_wake;   // write wake sample
    logic conv_clear;  // clear accumulator, j := 0
    logic conv_step;   // one multiply-accumulate
    logic conv_finish; // start scaling of sum
    logic scale_step;  // register scaled product
    logic volt_load;   // load voltage result into output register
    logic next_bin;    // advance b
    logic hist_clear;  // clear one histogram entry
  } thwc_cmd_t;

  typedef struct packed {
    logic div_done;
    logic j_last;
    logic b_last;
    logic nb_zero;
    logic clr_last;
  } thwc_stat_t;

endpackage

### src/thwc_ctrl.sv
// ----------------------------------------------------------------------------
// thwc_ctrl
// Sequencer: accepts input words, steps the divider, MAC and clear sweep.
// ----------------------------------------------------------------------------
module thwc_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [1:0]           mode,
  input  logic                 out_busy,
  input  thwc_pkg::thwc_stat_t stat,
  output thwc_pkg::thwc_cmd_t  cmd
);

  typedef enum logic [8:0] {
    S_IDLE  = 9'b0_0000_0001,
    S_DIV   = 9'b0_0000_0010,
    S_BINW  = 9'b0_0000_0100,
    S_MAC   = 9'b0_0000_1000,
    S_SCALE = 9'b0_0001_0000,
    S_SAT   = 9'b0_0010_0000,
    S_EMIT  = 9'b0_0100_0000,
    S_CLR   = 9'b0_1000_0000,
    S_BINR  = 9'b1_0000_0000
  } state_t;

  state_t state, state_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    cmd = '0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          unique case (mode)
            thwc_pkg::MODE_LOAD: cmd.load_wake = 1'b1;
            thwc_pkg::MODE_BIN: begin
              cmd.div_start = 1'b1;
              state_next = S_DIV;
            end
            thwc_pkg::MODE_COMPUTE: begin
              cmd.conv_clear = 1'b1;
              state_next = stat.nb_zero ? S_CLR : S_MAC;
            end
            default: ;
          endcase
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (stat.div_done) state_next = S_BINR;
      end
      // quotient is final; the histogram entry of the bin is read here
      S_BINR: begin
        state_next = S_BINW;
      end
      S_BINW: begin
        if (!out_busy) begin
          cmd.bin_finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_MAC: begin
        cmd.conv_step = 1'b1;
        if (stat.j_last) state_next = S_SCALE;
      end
      S_SCALE: begin
        cmd.conv_finish = 1'b1;
        state_next = S_SAT;
      end
      S_SAT: begin
        cmd.scale_step = 1'b1;
        state_next = S_EMIT;
      end
      S_EMIT: begin
        if (!out_busy) begin
          cmd.volt_load = 1'b1;
          if (stat.b_last) begin
            state_next = S_CLR;
          end else begin
            cmd.next_bin = 1'b1;
            cmd.conv_clear = 1'b1;
            state_next = S_MAC;
          end
        end
      end
      S_CLR: begin
        cmd.hist_clear = 1'b1;
        if (stat.clr_last) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // sweep the histogram clear right after reset
  always_ff @(posedge clk) begin
    if (rst) state <= S_CLR;
    else     state <= state_next;
  end

endmodule

### src/thwc_dp.sv
// ----------------------------------------------------------------------------
// thwc_dp
// Datapath: divider, histogram, wake memory, MAC, scaling and output word.
// ----------------------------------------------------------------------------
module thwc_dp #(
  parameter int MAX_BINS        = 64,
  parameter int MAX_WAKE_POINTS = 256,
  parameter int SCALE_SHIFT     = 16,
  parameter int COUNT_WIDTH     = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [2:0]           cfg_index,
  input  logic [31:0]          cfg_data,
  input  logic [7:0]           wake_index,
  input  logic signed [17:0]   wake_value,
  input  logic signed [31:0]   arrival_time,
  input  thwc_pkg::thwc_cmd_t  cmd,
  output thwc_pkg::thwc_stat_t stat,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic                 out_busy,
  output logic                 kind,
  output logic [5:0]           bin_index,
  output logic                 binned,
  output logic signed [47:0]   voltage,
  output logic [15:0]          binned_total,
  output logic                 last
);

  localparam int BW = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1;
  localparam int WW = (MAX_WAKE_POINTS > 1) ? $clog2(MAX_WAKE_POINTS) : 1;
  localparam logic [COUNT_WIDTH-1:0] CMAX = '1;
  localparam int DIVN = 35; // dividend magnitude bits
  localparam logic signed [47:0] SLIM = (48'sd1 <<< 46) - 48'sd1;

  // configuration
  logic signed [31:0] first_bin_time;
  logic [30:0]        bin_width;
  logic [6:0]         bin_count;
  logic [8:0]         wake_length;
  logic [7:0]         wake_origin;
  logic signed [17:0] scale;

  always_ff @(posedge clk) begin
    if (rst) begin
      first_bin_time <= '0;
      bin_width      <= 31'd1;
      bin_count      <= 7'd64;
      wake_length    <= 9'd256;
      wake_origin    <= '0;
      scale          <= 18'sd65536;
    end else if (cfg_we) begin
      unique case (cfg_index)
        thwc_pkg::REG_FIRST:  first_bin_time <= cfg_data;
        thwc_pkg::REG_WIDTH:  bin_width      <= cfg_data[30:0];
        thwc_pkg::REG_COUNT:  bin_count      <= cfg_data[6:0];
        thwc_pkg::REG_WLEN:   wake_length    <= cfg_data[8:0];
        thwc_pkg::REG_ORIGIN: wake_origin    <= cfg_data[7:0];
        thwc_pkg::REG_SCALE:  scale          <= cfg_data[17:0];
        default: ;
      endcase
    end
  end

  logic [6:0]  nb;
  logic [12:0] n2;
  assign nb = (bin_count > 7'(MAX_BINS)) ? 7'(MAX_BINS) : bin_count;
  assign n2 = (13'(wake_length) > 13'(MAX_WAKE_POINTS)) ? 13'(MAX_WAKE_POINTS)
                                                        : 13'(wake_length);

  // restoring divider on magnitudes: num = 2d + w, den = 2w
  logic [31:0]     w_eff;
  logic [DIVN-1:0] quo;
  logic [32:0]     rem;
  logic [32:0]     den;
  logic            neg;
  logic [5:0]      dcnt;
  logic signed [34:0] num;
  logic [33:0]     trial;

  assign w_eff = (bin_width == '0) ? 32'd1 : {1'b0, bin_width};
  assign num = 35'(2 * (35'(arrival_time) - 35'(first_bin_time))) + 35'(w_eff);
  assign trial = {rem, quo[DIVN-1]} - {1'b0, den};

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      neg  <= num[34];
      quo  <= num[34] ? DIVN'(-num) : DIVN'(num);
      rem  <= '0;
      den  <= {w_eff, 1'b0};
      dcnt <= 6'(DIVN - 1);
    end else if (cmd.div_step) begin
      if (!trial[33]) begin
        rem <= trial[32:0];
        quo <= {quo[DIVN-2:0], 1'b1};
      end else begin
        rem <= {rem[31:0], quo[DIVN-1]};
        quo <= {quo[DIVN-2:0], 1'b0};
      end
      dcnt <= dcnt - 6'd1;
    end
  end
  assign stat.div_done = (dcnt == '0);

  // bin = neg ? -(quo + (rem!=0)) : quo ; only nonnegative bins are valid
  logic bin_ok;
  assign bin_ok = !neg || (quo == '0 && rem == '0);
  logic in_range;
  assign in_range = bin_ok && (quo < DIVN'(nb));

  // histogram: registered read, cleared by the sweep after reset and compute
  logic [COUNT_WIDTH-1:0] hist [MAX_BINS];
  logic [COUNT_WIDTH-1:0] bcount;
  logic [BW-1:0]          qb;
  logic [BW-1:0]          hist_addr;
  assign qb = quo[BW-1:0];

  logic [6:0] b, j, clr;
  logic signed [63:0] acc;
  logic signed [63:0] acc_next;
  logic signed [17:0] wake_rd;
  logic [COUNT_WIDTH-1:0] hist_rd;
  logic mac_en, mac_ok;

  logic signed [17:0] wake_mem [MAX_WAKE_POINTS];
  always_ff @(posedge clk) begin
    if (cmd.load_wake && 32'(wake_index) < 32'(MAX_WAKE_POINTS))
      wake_mem[WW'(wake_index)] <= wake_value;
  end

  // MAC index k = b + origin - j
  logic signed [14:0] k;
  assign k = 15'(b) + 15'(wake_origin) - 15'(j);
  logic k_ok;
  assign k_ok = !k[14] && (k < 15'(n2));

  // MAC walks j; otherwise look up the entry of the quotient's bin
  assign hist_addr = cmd.conv_step ? BW'(j) : qb;

  always_ff @(posedge clk) begin
    wake_rd <= wake_mem[WW'(k)];
    hist_rd <= hist[hist_addr];
    mac_ok  <= k_ok;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mac_en <= 1'b0;
    end else begin
      mac_en <= cmd.conv_step;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.bin_finish && in_range) begin
      if (hist_rd != CMAX) hist[qb] <= hist_rd + 1'b1;
    end else if (cmd.hist_clear) begin
      hist[BW'(clr)] <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bcount <= '0;
    end else if (cmd.bin_finish && in_range) begin
      if (bcount != CMAX) bcount <= bcount + 1'b1;
    end else if (cmd.hist_clear) begin
      if (clr == 7'(MAX_BINS - 1)) bcount <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || !cmd.hist_clear) clr <= '0;
    else clr <= clr + 7'd1;
  end
  assign stat.clr_last = (clr == 7'(MAX_BINS - 1));

  always_ff @(posedge clk) begin
    if (rst) b <= '0;
    else if (cmd.hist_clear) b <= '0;
    else if (cmd.next_bin) b <= b + 7'd1;
  end

  always_ff @(posedge clk) begin
    if (cmd.conv_clear) j <= '0;
    else if (cmd.conv_step) j <= j + 7'd1;
  end
  assign stat.j_last  = (j == nb - 7'd1);
  assign stat.b_last  = (b == nb - 7'd1);
  assign stat.nb_zero = (nb == '0);

  logic signed [63:0] prod;
  assign prod = 64'($signed({1'b0, hist_rd})) * 64'(wake_rd);
  assign acc_next = acc + ((mac_en && mac_ok) ? prod : 64'sd0);

  always_ff @(posedge clk) begin
    if (cmd.conv_clear) acc <= '0;
    else acc <= acc_next;
  end

  // scaling: the last product lands in S_SCALE, so saturate the running sum
  // with it folded in, then multiply
  logic signed [47:0] sat_s;
  logic signed [65:0] scaled;
  logic signed [47:0] vout;
  always_ff @(posedge clk) begin
    if (cmd.conv_finish)
      sat_s <= (acc_next > 64'(SLIM)) ? SLIM :
               (acc_next < -64'(SLIM)) ? -SLIM : 48'(acc_next);
    if (cmd.scale_step)
      scaled <= (66'(sat_s) * 66'(scale)) >>> SCALE_SHIFT;
  end
  assign vout = (scaled > 66'sd140737488355327) ? 48'sd140737488355327 :
                (scaled < -66'sd140737488355328) ? -48'sd140737488355328 :
                48'(scaled);

  // output register
  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (cmd.bin_finish || cmd.volt_load) out_valid <= 1'b1;
    else if (out_ready) out_valid <= 1'b0;
  end
  assign out_busy = out_valid && !out_ready;

  always_ff @(posedge clk) begin
    if (cmd.bin_finish) begin
      kind         <= 1'b0;
      bin_index    <= in_range ? 6'(quo) : '0;
      binned       <= in_range;
      voltage      <= '0;
      binned_total <= 16'((in_range && bcount != CMAX) ? bcount + 1'b1 : bcount);
      last         <= 1'b0;
    end else if (cmd.volt_load) begin
      kind         <= 1'b1;
      bin_index    <= 6'(b);
      binned       <= 1'b0;
      voltage      <= vout;
      binned_total <= 16'(bcount);
      last         <= stat.b_last;
    end
  end

endmodule

### src/time_histogram_wake_convolution_unit.sv
// ----------------------------------------------------------------------------
// time_histogram_wake_convolution_unit
// Bins arrival times into a histogram and convolves it with a wake table.
// ----------------------------------------------------------------------------
// One word in at a time. After reset the block first clears the histogram,
// one entry a cycle, and in_ready stays low until the sweep ends. A load
// word writes the wake table. A bin word runs a 35-step restoring divider,
// then reads the histogram entry in S_BINR, and in S_BINW updates it and
// loads the result. A compute word walks every bin b and, per bin, one
// multiply-accumulate a cycle over all bins j, then saturates the sum in
// S_SCALE, scales it in S_SAT and loads the voltage in S_EMIT, followed by
// a clearing sweep over the histogram. A waiting result holds the
// sequencer until it is taken.
module time_histogram_wake_convolution_unit #(
  parameter int MAX_BINS        = 64,
  parameter int MAX_WAKE_POINTS = 256,
  parameter int SCALE_SHIFT     = 16,
  parameter int COUNT_WIDTH     = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [2:0]          cfg_index,
  input  logic [31:0]         cfg_data,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [1:0]          mode,
  input  logic [7:0]          wake_index,
  input  logic signed [17:0]  wake_value,
  input  logic signed [31:0]  arrival_time,
  output logic                out_valid,
  input  logic                out_ready,
  output logic                kind,
  output logic [5:0]          bin_index,
  output logic                binned,
  output logic signed [47:0]  voltage,
  output logic [15:0]         binned_total,
  output logic                last
);

  thwc_pkg::thwc_cmd_t  cmd;
  thwc_pkg::thwc_stat_t stat;
  logic out_busy;

  // controller sequences, datapath computes
  thwc_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
    .mode(mode), .out_busy(out_busy), .stat(stat), .cmd(cmd)
  );

  thwc_dp #(
    .MAX_BINS(MAX_BINS), .MAX_WAKE_POINTS(MAX_WAKE_POINTS),
    .SCALE_SHIFT(SCALE_SHIFT), .COUNT_WIDTH(COUNT_WIDTH)
  ) u_dp (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .wake_index(wake_index), .wake_value(wake_value),
    .arrival_time(arrival_time), .cmd(cmd), .stat(stat),
    .out_valid(out_valid), .out_ready(out_ready), .out_busy(out_busy),
    .kind(kind), .bin_index(bin_index), .binned(binned), .voltage(voltage),
    .binned_total(binned_total), .last(last)
  );

  // a bin report never claims to be the last voltage
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !kind |-> !last) else $error("bin word with last");

  // a new result is never loaded over one still waiting
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid) else $error("output word dropped");

  // a word that did not bin reports bin zero
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !kind && !binned |-> bin_index == '0) else $error("bad bin");

endmodule
